// ===== hw/rtl/sdtr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtr_pkg: shared types and constants for the speed dependent torque ramp
// Holds the register map, the controller command codes, the path codes and
// the fixed datapath widths used by the controller and the datapath.
// ----------------------------------------------------------------------------
package sdtr_pkg;

    // field and port widths
    localparam int DATA_W  = 16;
    localparam int ADDR_W  = 5;
    localparam int PDATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DECEL_RAMP_START       = 3'd0;
    localparam logic [2:0] REG_DECEL_RAMP_END         = 3'd1;
    localparam logic [2:0] REG_DECEL_POWER_LOW_SPEED  = 3'd2;
    localparam logic [2:0] REG_DECEL_POWER_HIGH_SPEED = 3'd3;
    localparam logic [2:0] REG_LIMIT_RAMP_START       = 3'd4;
    localparam logic [2:0] REG_LIMIT_RAMP_END         = 3'd5;
    localparam logic [2:0] REG_LIMIT_POWER_LOW_SPEED  = 3'd6;
    localparam logic [2:0] REG_LIMIT_POWER_HIGH_SPEED = 3'd7;

    // ramp selector codes
    localparam logic [1:0] SEL_NONE     = 2'd0;
    localparam logic [1:0] SEL_DECEL    = 2'd1;
    localparam logic [1:0] SEL_LIMIT    = 2'd2;
    localparam logic [1:0] SEL_NONE_ALT = 2'd3;

    // 100 percent in Q8.8
    localparam int LIMIT_SCALE = 25600;

    // divider: 17 quotient bits plus one overflow bit
    localparam int DIV_STEPS = 18;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [DATA_W-1:0] decel_ramp_start;
        logic [DATA_W-1:0] decel_ramp_end;
        logic [DATA_W-1:0] decel_power_low_speed;
        logic [DATA_W-1:0] decel_power_high_speed;
        logic [DATA_W-1:0] limit_ramp_start;
        logic [DATA_W-1:0] limit_ramp_end;
        logic [DATA_W-1:0] limit_power_low_speed;
        logic [DATA_W-1:0] limit_power_high_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        decel_ramp_start:       16'd0,
        decel_ramp_end:         16'd10240,
        decel_power_low_speed:  16'd25600,
        decel_power_high_speed: 16'd12800,
        limit_ramp_start:       16'd6400,
        limit_ramp_end:         16'd8192,
        limit_power_low_speed:  16'd25600,
        limit_power_high_speed: 16'd0
    };

    // how a request is processed
    typedef enum logic [1:0] {
        PATH_PASS,    // torque passes through
        PATH_BYPASS,  // deceleration with no floor, state follows torque
        PATH_FLAT,    // limiting with a flat factor
        PATH_CALC     // full multiply and divide sequence
    } path_t;

    // datapath commands
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_PREP,
        OP_MULLO,
        OP_MULHI,
        OP_DIVLD,
        OP_DIV,
        OP_FIN
    } op_t;

    // controller states
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_CLASS = 11'b000_0000_0010,
        ST_MUL1  = 11'b000_0000_0100,
        ST_MUL2  = 11'b000_0000_1000,
        ST_MUL3  = 11'b000_0001_0000,
        ST_PREP  = 11'b000_0010_0000,
        ST_MULLO = 11'b000_0100_0000,
        ST_MULHI = 11'b000_1000_0000,
        ST_DIVLD = 11'b001_0000_0000,
        ST_DIV   = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } state_t;

endpackage

// ===== hw/rtl/speed_dependent_torque_ramp_top.sv =====
// ----------------------------------------------------------------------------
// speed_dependent_torque_ramp_top: torque command ramp filter
// Per request: pass-through, dynamic deceleration floor, or speed dependent
// power limiting of a signed torque command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries ramp_select, speed and
//   torque_in; output channel (out_valid/out_ready) carries torque_out.
//   One request is processed at a time. in_ready is high while the block is
//   idle. Pass-through and a deceleration ramp with no floor go straight to
//   the final step; a flat limiting factor runs the prepare step, two
//   partial products and the divide steps; the full sequence runs three
//   multiplies, two partial products, 18 restoring divide steps on one shared
//   multiplier and one subtractor. The next request can be taken in the
//   cycle in which out_valid rises.
//   The result sits in an output register; if the receiver stalls, a
//   further request still runs and waits in its last step until that
//   register is taken.
//   Configuration registers sit on the APB port at byte address 4*index.
//   They must be written by the user only while the block is idle; the
//   block does not enforce it. Reset loads the register defaults, clears
//   the stored deceleration output to zero and empties the output register.
// ----------------------------------------------------------------------------
module speed_dependent_torque_ramp_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sdtr_pkg::ADDR_W-1:0]        paddr,
    input  logic [sdtr_pkg::PDATA_W-1:0]       pwdata,
    output logic [sdtr_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         ramp_select,
    input  logic [sdtr_pkg::DATA_W-1:0]        speed,
    input  logic signed [sdtr_pkg::DATA_W-1:0] torque_in,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sdtr_pkg::DATA_W-1:0] torque_out
);

    sdtr_pkg::cfg_t  cfg;
    sdtr_pkg::op_t   op;
    sdtr_pkg::path_t path;

    // configuration registers
    sdtr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    sdtr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .path      (path),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .op        (op)
    );

    // arithmetic
    sdtr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .cfg         (cfg),
        .ramp_select (ramp_select),
        .speed       (speed),
        .torque_in   (torque_in),
        .path        (path),
        .torque_out  (torque_out)
    );

    // a request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("block still ready after taking a request");

    // a new result only appears at the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");

    // pass-through requests come back unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid
        && (ramp_select == sdtr_pkg::SEL_NONE || ramp_select == sdtr_pkg::SEL_NONE_ALT)
        |=> ##2 (out_valid && (torque_out == $past(torque_in, 3))))
    else $error("pass-through result wrong or late");

endmodule

// ===== hw/rtl/sdtr_cfg.sv =====
// ----------------------------------------------------------------------------
// sdtr_cfg: configuration register file
// Eight 16-bit registers behind an APB-style port, written in the access
// phase and read back zero-extended.
// ----------------------------------------------------------------------------
module sdtr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdtr_pkg::ADDR_W-1:0]  paddr,
    input  logic [sdtr_pkg::PDATA_W-1:0] pwdata,
    output logic [sdtr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output sdtr_pkg::cfg_t               cfg
);

    sdtr_pkg::cfg_t                cfg_reg;
    sdtr_pkg::cfg_t                cfg_next;
    logic [sdtr_pkg::DATA_W-1:0]   wdata;
    logic [sdtr_pkg::DATA_W-1:0]   rdata;
    logic [2:0]                    index;

    assign pready = 1'b1;
    assign wdata  = pwdata[sdtr_pkg::DATA_W-1:0];
    assign index  = paddr[4:2];
    assign cfg    = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (index)
                sdtr_pkg::REG_DECEL_RAMP_START:       cfg_next.decel_ramp_start       = wdata;
                sdtr_pkg::REG_DECEL_RAMP_END:         cfg_next.decel_ramp_end         = wdata;
                sdtr_pkg::REG_DECEL_POWER_LOW_SPEED:  cfg_next.decel_power_low_speed  = wdata;
                sdtr_pkg::REG_DECEL_POWER_HIGH_SPEED: cfg_next.decel_power_high_speed = wdata;
                sdtr_pkg::REG_LIMIT_RAMP_START:       cfg_next.limit_ramp_start       = wdata;
                sdtr_pkg::REG_LIMIT_RAMP_END:         cfg_next.limit_ramp_end         = wdata;
                sdtr_pkg::REG_LIMIT_POWER_LOW_SPEED:  cfg_next.limit_power_low_speed  = wdata;
                sdtr_pkg::REG_LIMIT_POWER_HIGH_SPEED: cfg_next.limit_power_high_speed = wdata;
                default:                              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sdtr_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (index)
            sdtr_pkg::REG_DECEL_RAMP_START:       rdata = cfg_reg.decel_ramp_start;
            sdtr_pkg::REG_DECEL_RAMP_END:         rdata = cfg_reg.decel_ramp_end;
            sdtr_pkg::REG_DECEL_POWER_LOW_SPEED:  rdata = cfg_reg.decel_power_low_speed;
            sdtr_pkg::REG_DECEL_POWER_HIGH_SPEED: rdata = cfg_reg.decel_power_high_speed;
            sdtr_pkg::REG_LIMIT_RAMP_START:       rdata = cfg_reg.limit_ramp_start;
            sdtr_pkg::REG_LIMIT_RAMP_END:         rdata = cfg_reg.limit_ramp_end;
            sdtr_pkg::REG_LIMIT_POWER_LOW_SPEED:  rdata = cfg_reg.limit_power_low_speed;
            sdtr_pkg::REG_LIMIT_POWER_HIGH_SPEED: rdata = cfg_reg.limit_power_high_speed;
            default:                              rdata = '0;
        endcase
    end

    assign prdata = {{(sdtr_pkg::PDATA_W-sdtr_pkg::DATA_W){1'b0}}, rdata};

endmodule

// ===== hw/rtl/sdtr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdtr_ctrl: sequencing controller
// One-hot state machine that walks the datapath through the multiply,
// prepare, multiply and divide steps, and owns the output valid flag.
// ----------------------------------------------------------------------------
module sdtr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_ready,
    input  sdtr_pkg::path_t      path,
    output logic                 in_ready,
    output logic                 out_valid,
    output sdtr_pkg::op_t        op
);

    sdtr_pkg::state_t              state_reg;
    sdtr_pkg::state_t              state_next;
    logic [sdtr_pkg::CNT_W-1:0]    cnt_reg;
    logic [sdtr_pkg::CNT_W-1:0]    cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    assign in_ready  = (state_reg == sdtr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op             = sdtr_pkg::OP_IDLE;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            sdtr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = sdtr_pkg::OP_LOAD;
                    state_next = sdtr_pkg::ST_CLASS;
                end
            end
            sdtr_pkg::ST_CLASS:
            begin
                case (path) inside
                    sdtr_pkg::PATH_PASS, sdtr_pkg::PATH_BYPASS:
                        state_next = sdtr_pkg::ST_FIN;
                    sdtr_pkg::PATH_FLAT:
                        state_next = sdtr_pkg::ST_PREP;
                    default:
                        state_next = sdtr_pkg::ST_MUL1;
                endcase
            end
            sdtr_pkg::ST_MUL1:
            begin
                op         = sdtr_pkg::OP_MUL1;
                state_next = sdtr_pkg::ST_MUL2;
            end
            sdtr_pkg::ST_MUL2:
            begin
                op         = sdtr_pkg::OP_MUL2;
                state_next = sdtr_pkg::ST_MUL3;
            end
            sdtr_pkg::ST_MUL3:
            begin
                op         = sdtr_pkg::OP_MUL3;
                state_next = sdtr_pkg::ST_PREP;
            end
            sdtr_pkg::ST_PREP:
            begin
                op         = sdtr_pkg::OP_PREP;
                state_next = sdtr_pkg::ST_MULLO;
            end
            sdtr_pkg::ST_MULLO:
            begin
                op         = sdtr_pkg::OP_MULLO;
                state_next = sdtr_pkg::ST_MULHI;
            end
            sdtr_pkg::ST_MULHI:
            begin
                op         = sdtr_pkg::OP_MULHI;
                state_next = sdtr_pkg::ST_DIVLD;
            end
            sdtr_pkg::ST_DIVLD:
            begin
                op         = sdtr_pkg::OP_DIVLD;
                cnt_next   = sdtr_pkg::CNT_W'(sdtr_pkg::DIV_STEPS - 1);
                state_next = sdtr_pkg::ST_DIV;
            end
            sdtr_pkg::ST_DIV:
            begin
                op = sdtr_pkg::OP_DIV;
                if (cnt_reg == '0)
                begin
                    state_next = sdtr_pkg::ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            sdtr_pkg::ST_FIN:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    op             = sdtr_pkg::OP_FIN;
                    out_valid_next = 1'b1;
                    state_next     = sdtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdtr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtr_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/sdtr_dp.sv =====
// ----------------------------------------------------------------------------
// sdtr_dp: arithmetic datapath
// One shared registered 18x19 multiplier, an accumulator, and a restoring
// divider that yields one quotient bit per step. Holds the previous
// deceleration output and the output register.
// ----------------------------------------------------------------------------
module sdtr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdtr_pkg::op_t                     op,
    input  sdtr_pkg::cfg_t                    cfg,
    input  logic [1:0]                        ramp_select,
    input  logic [sdtr_pkg::DATA_W-1:0]       speed,
    input  logic signed [sdtr_pkg::DATA_W-1:0] torque_in,
    output sdtr_pkg::path_t                   path,
    output logic signed [sdtr_pkg::DATA_W-1:0] torque_out
);

    // request registers
    logic [1:0]          sel_reg;
    logic [15:0]         spd_reg;
    logic signed [15:0]  tin_reg;
    logic signed [15:0]  prev_reg;
    logic signed [15:0]  prev_next;
    logic signed [15:0]  res_reg;

    // arithmetic registers
    logic signed [36:0]  prod_reg;
    logic signed [34:0]  acc_reg;
    logic [31:0]         den_reg;
    logic [15:0]         xmag_reg;
    logic [34:0]         ymag_reg;
    logic                neg_reg;
    logic [50:0]         rem_reg;
    logic [48:0]         dsh_reg;
    logic [17:0]         q_reg;

    // configuration-derived terms
    logic                is_decel;
    logic signed [16:0]  wd;
    logic signed [16:0]  wd_neg;
    logic [16:0]         awd;
    logic signed [16:0]  dpl_m_ph;
    logic signed [16:0]  wl;
    logic signed [16:0]  spd_m_st;
    logic signed [16:0]  lph_m_pl;
    logic                below;
    logic                above;
    logic                flat;
    logic                flat_hi;
    logic                bypass;

    // multiplier
    logic signed [17:0]  mul_a;
    logic signed [18:0]  mul_b;
    logic signed [36:0]  mul_p;

    // prepare step
    logic signed [34:0]  acc_neg;
    logic [34:0]         acc_abs;
    logic signed [35:0]  y;
    logic signed [35:0]  y_neg;
    logic [34:0]         y_abs;
    logic [31:0]         den_sel;
    logic signed [15:0]  xv;
    logic signed [16:0]  x_neg;
    logic [15:0]         x_abs;

    // divide step
    logic                ge;
    logic [50:0]         rem_sub;

    // final step
    logic [16:0]         qmag;
    logic [16:0]         qneg;
    logic                ovf;
    logic signed [15:0]  fl;
    logic signed [15:0]  res_sel;

    assign torque_out = res_reg;
    assign is_decel   = (sel_reg == sdtr_pkg::SEL_DECEL);

    // widths and slopes from the registers
    assign wd       = $signed({1'b0, cfg.decel_ramp_end}) - $signed({1'b0, cfg.decel_ramp_start});
    assign wd_neg   = -wd;
    assign awd      = wd[16] ? unsigned'(wd_neg) : unsigned'(wd);
    assign dpl_m_ph = $signed({1'b0, cfg.decel_power_low_speed})
                    - $signed({1'b0, cfg.decel_power_high_speed});
    assign wl       = $signed({1'b0, cfg.limit_ramp_end}) - $signed({1'b0, cfg.limit_ramp_start});
    assign spd_m_st = $signed({1'b0, spd_reg}) - $signed({1'b0, cfg.limit_ramp_start});
    assign lph_m_pl = $signed({1'b0, cfg.limit_power_high_speed})
                    - $signed({1'b0, cfg.limit_power_low_speed});
    assign below    = spd_reg < cfg.limit_ramp_start;
    assign above    = spd_reg > cfg.limit_ramp_end;
    assign flat     = below || above || (cfg.limit_ramp_end == cfg.limit_ramp_start);
    assign flat_hi  = !below && above;
    assign bypass   = (wd == '0) || (cfg.decel_power_high_speed == '0);

    // path classification
    always_comb
    begin
        case (sel_reg)
            sdtr_pkg::SEL_DECEL: path = bypass ? sdtr_pkg::PATH_BYPASS : sdtr_pkg::PATH_CALC;
            sdtr_pkg::SEL_LIMIT: path = flat ? sdtr_pkg::PATH_FLAT : sdtr_pkg::PATH_CALC;
            default:             path = sdtr_pkg::PATH_PASS;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            sdtr_pkg::OP_MUL1:
            begin
                if (is_decel)
                begin
                    mul_a = $signed({2'b00, cfg.decel_power_high_speed});
                    mul_b = 19'(wd);
                end
                else
                begin
                    mul_a = $signed({2'b00, cfg.limit_power_low_speed});
                    mul_b = 19'(wl);
                end
            end
            sdtr_pkg::OP_MUL2:
            begin
                if (is_decel)
                begin
                    mul_a = $signed({2'b00, spd_reg});
                    mul_b = 19'(dpl_m_ph);
                end
                else
                begin
                    mul_a = 18'(spd_m_st);
                    mul_b = 19'(lph_m_pl);
                end
            end
            sdtr_pkg::OP_MUL3:
            begin
                if (is_decel)
                begin
                    mul_a = $signed({2'b00, cfg.decel_power_high_speed});
                    mul_b = $signed({2'b00, awd});
                end
                else
                begin
                    mul_a = 18'(sdtr_pkg::LIMIT_SCALE);
                    mul_b = 19'(wl);
                end
            end
            sdtr_pkg::OP_MULLO:
            begin
                mul_a = $signed({2'b00, xmag_reg});
                mul_b = $signed({1'b0, ymag_reg[17:0]});
            end
            sdtr_pkg::OP_MULHI:
            begin
                mul_a = $signed({2'b00, xmag_reg});
                mul_b = $signed({2'b00, ymag_reg[34:18]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // prepare: divisor, multiplicand magnitudes and result sign
    assign acc_neg = -acc_reg;
    assign acc_abs = acc_reg[34] ? unsigned'(acc_neg) : unsigned'(acc_reg);

    always_comb
    begin
        if (is_decel)
        begin
            den_sel = prod_reg[31:0];
            y       = $signed({4'b0000, prod_reg[31:0]}) - $signed({1'b0, acc_abs});
        end
        else if (flat)
        begin
            den_sel = 32'(sdtr_pkg::LIMIT_SCALE);
            y       = $signed({20'd0, flat_hi ? cfg.limit_power_high_speed
                                              : cfg.limit_power_low_speed});
        end
        else
        begin
            den_sel = prod_reg[31:0];
            y       = $signed({4'b0000, acc_reg[31:0]});
        end
    end

    assign y_neg = -y;
    assign y_abs = y[35] ? y_neg[34:0] : y[34:0];
    assign xv    = is_decel ? prev_reg : tin_reg;
    assign x_neg = -$signed({xv[15], xv});
    assign x_abs = xv[15] ? x_neg[15:0] : xv[15:0];

    // one restoring divide step
    assign ge      = rem_reg >= {2'b00, dsh_reg};
    assign rem_sub = rem_reg - {2'b00, dsh_reg};

    // quotient to saturated signed value, then mode selection
    assign qmag = q_reg[16:0];
    assign ovf  = q_reg[17];
    assign qneg = -qmag;

    always_comb
    begin
        if (neg_reg)
        begin
            fl = (ovf || (qmag > 17'd32768)) ? 16'sh8000 : $signed(qneg[15:0]);
        end
        else
        begin
            fl = (ovf || (qmag > 17'd32767)) ? 16'sh7fff : $signed(qmag[15:0]);
        end
    end

    always_comb
    begin
        prev_next = prev_reg;
        if ((path == sdtr_pkg::PATH_PASS) || (path == sdtr_pkg::PATH_BYPASS))
        begin
            res_sel = tin_reg;
        end
        else if (is_decel)
        begin
            res_sel = (tin_reg < fl) ? fl : tin_reg;
        end
        else
        begin
            res_sel = fl[15] ? tin_reg : fl;
        end
        if (is_decel)
        begin
            prev_next = res_sel;
        end
    end

    // deceleration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (op == sdtr_pkg::OP_FIN)
        begin
            prev_reg <= prev_next;
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        case (op)
            sdtr_pkg::OP_LOAD:
            begin
                sel_reg <= ramp_select;
                spd_reg <= speed;
                tin_reg <= torque_in;
            end
            sdtr_pkg::OP_MUL1:
            begin
                prod_reg <= mul_p;
            end
            sdtr_pkg::OP_MUL2:
            begin
                prod_reg <= mul_p;
                acc_reg  <= prod_reg[34:0];
            end
            sdtr_pkg::OP_MUL3:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + prod_reg[34:0];
            end
            sdtr_pkg::OP_PREP:
            begin
                den_reg  <= den_sel;
                xmag_reg <= x_abs;
                ymag_reg <= y_abs;
                neg_reg  <= xv[15] ^ y[35];
            end
            sdtr_pkg::OP_MULLO:
            begin
                prod_reg <= mul_p;
            end
            sdtr_pkg::OP_MULHI:
            begin
                prod_reg <= mul_p;
                rem_reg  <= {17'd0, prod_reg[33:0]};
            end
            sdtr_pkg::OP_DIVLD:
            begin
                rem_reg <= rem_reg + {prod_reg[32:0], 18'd0};
                dsh_reg <= {den_reg, 17'd0};
                q_reg   <= '0;
            end
            sdtr_pkg::OP_DIV:
            begin
                if (ge)
                begin
                    rem_reg <= rem_sub;
                end
                q_reg   <= {q_reg[16:0], ge};
                dsh_reg <= {1'b0, dsh_reg[48:1]};
            end
            sdtr_pkg::OP_FIN:
            begin
                res_reg <= res_sel;
            end
            default:
            begin
            end
        endcase
    end

endmodule
